// File: sv/alt_pkg.sv
package alt_pkg;

  localparam int LENGTH_LIMIT = 255;
  localparam int PREFIX_DEPTH = 5;
  localparam int PIDX_W       = $clog2(PREFIX_DEPTH);
  localparam int KW_CHARS     = 5;

  localparam logic [7:0] WORD_CAP = 8'((LENGTH_LIMIT < 255) ? LENGTH_LIMIT : 255);

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_HASH   = "#";
  localparam logic [7:0] CH_AT     = "@";
  localparam logic [7:0] CH_COMMA  = ",";
  localparam logic [7:0] CH_SEMI   = ";";
  localparam logic [7:0] CH_COLON  = ":";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_ONE    = "1";
  localparam logic [7:0] CH_X      = "x";
  localparam logic [7:0] CH_B      = "b";

  // shape flag bit positions
  localparam int SH_DEC   = 0;
  localparam int SH_HEX   = 1;
  localparam int SH_BIN   = 2;
  localparam int SH_LDECL = 3;
  localparam int SH_LABEL = 4;

  typedef enum logic [4:0] {
    TK_UNKNOWN,
    TK_COMMA,
    TK_AT,
    TK_ENDL,
    TK_COLON,
    TK_LPAREN,
    TK_RPAREN,
    TK_TIME,
    TK_DISPTYPE,
    TK_OP,
    TK_FLAG,
    TK_COND,
    TK_REG,
    TK_CHAR,
    TK_DEC,
    TK_HEX,
    TK_BIN,
    TK_LABELDECL,
    TK_LABEL
  } tok_class_t;

  typedef struct packed {
    tok_class_t  cls;
    logic [7:0]  length;
    logic [7:0]  column;
    logic        last;
  } token_t;

  // prefix[0] is the first character of the word
  typedef struct packed {
    logic [7:0]                 length;
    logic [4:0]                 shape;
    logic [KW_CHARS-1:0][7:0]   prefix;
  } word_t;

  function automatic tok_class_t punct_class(logic [7:0] c);
    tok_class_t r;
    unique case (c)
      CH_COMMA:  r = TK_COMMA;
      CH_AT:     r = TK_AT;
      CH_SEMI:   r = TK_ENDL;
      CH_COLON:  r = TK_COLON;
      CH_LPAREN: r = TK_LPAREN;
      CH_RPAREN: r = TK_RPAREN;
      default:   r = TK_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage

// File: sv/alt_classify.sv
module alt_classify (
  input  alt_pkg::word_t     word_i,
  output alt_pkg::tok_class_t cls_o
);

  localparam int NCH = alt_pkg::KW_CHARS;

  // keywords right-justified, lowercase where matched case-insensitively
  localparam logic [8*NCH-1:0] KW_TIME [3] = '{"s", "ms", "us"};
  localparam logic [8*NCH-1:0] KW_DISP [6] = '{"int", "char", "mem", "str", "hex", "bin"};
  localparam logic [8*NCH-1:0] KW_OP [23] = '{"add", "sub", "cmp", "copy", "push", "pop",
    "mul", "div", "mod", "and", "or", "not", "xor", "jump", "call", "ret",
    "input", "disp", "rand", "wait", "exit", "halt", "cls"};
  localparam logic [8*NCH-1:0] KW_FLAG [6] = '{"EQU", "ZRO", "POS", "NEG", "OVF", "ODD"};
  localparam logic [8*NCH-1:0] KW_COND [2] = '{"if", "ifnot"};
  localparam logic [8*NCH-1:0] KW_REG [16] = '{"ax", "bx", "cx", "dx", "ex", "fx", "di",
    "si", "ip", "sp", "r0", "r1", "r2", "r3", "r4", "r5"};

  function automatic int kw_len(logic [8*NCH-1:0] kw);
    int n;
    n = 0;
    for (int i = 0; i < NCH; i++) begin
      if (kw[8*i +: 8] != 8'd0) n++;
    end
    return n;
  endfunction

  function automatic logic kw_hit(alt_pkg::word_t w, logic [8*NCH-1:0] kw, logic fold_en);
    int               n;
    logic [8*NCH-1:0] kws;
    logic             hit;
    logic [7:0]       c;
    n   = kw_len(kw);
    kws = kw << (8 * (NCH - n));
    hit = (w.length == 8'(n));
    for (int i = 0; i < NCH; i++) begin
      c = w.prefix[i];
      if (fold_en && c >= "A" && c <= "Z") c = c + 8'd32;
      if (i < n && c != kws[8*(NCH-1-i) +: 8]) hit = 1'b0;
    end
    return hit;
  endfunction

  logic hit_time, hit_disp, hit_op, hit_flag, hit_cond, hit_reg;
  logic is_char;
  logic [7:0] len;
  logic [7:0] p0;

  assign len = word_i.length;
  assign p0  = word_i.prefix[0];

  always_comb begin
    hit_time = 1'b0;
    hit_disp = 1'b0;
    hit_op   = 1'b0;
    hit_flag = 1'b0;
    hit_cond = 1'b0;
    hit_reg  = 1'b0;
    for (int k = 0; k < 3; k++)  hit_time |= kw_hit(word_i, KW_TIME[k], 1'b0);
    for (int k = 0; k < 6; k++)  hit_disp |= kw_hit(word_i, KW_DISP[k], 1'b0);
    for (int k = 0; k < 23; k++) hit_op   |= kw_hit(word_i, KW_OP[k], 1'b1);
    for (int k = 0; k < 6; k++)  hit_flag |= kw_hit(word_i, KW_FLAG[k], 1'b0);
    for (int k = 0; k < 2; k++)  hit_cond |= kw_hit(word_i, KW_COND[k], 1'b1);
    for (int k = 0; k < 16; k++) hit_reg  |= kw_hit(word_i, KW_REG[k], 1'b0);
  end

  assign is_char = (p0 == alt_pkg::CH_QUOTE) &&
                   ((len == 8'd3 && word_i.prefix[2] == alt_pkg::CH_QUOTE) ||
                    (len == 8'd4 && word_i.prefix[3] == alt_pkg::CH_QUOTE &&
                     word_i.prefix[1] == alt_pkg::CH_BSLASH));

  always_comb begin
    if (len == 8'd1 && alt_pkg::punct_class(p0) != alt_pkg::TK_UNKNOWN)
      cls_o = alt_pkg::punct_class(p0);
    else if (hit_time)
      cls_o = alt_pkg::TK_TIME;
    else if (hit_disp)
      cls_o = alt_pkg::TK_DISPTYPE;
    else if (hit_op)
      cls_o = alt_pkg::TK_OP;
    else if (hit_flag)
      cls_o = alt_pkg::TK_FLAG;
    else if (hit_cond)
      cls_o = alt_pkg::TK_COND;
    else if (hit_reg)
      cls_o = alt_pkg::TK_REG;
    else if (is_char)
      cls_o = alt_pkg::TK_CHAR;
    else if (word_i.shape[alt_pkg::SH_DEC] && !(len == 8'd1 && p0 == alt_pkg::CH_MINUS))
      cls_o = alt_pkg::TK_DEC;
    else if (word_i.shape[alt_pkg::SH_HEX] && len > 8'd2)
      cls_o = alt_pkg::TK_HEX;
    else if (word_i.shape[alt_pkg::SH_BIN] && len > 8'd2)
      cls_o = alt_pkg::TK_BIN;
    else if (word_i.shape[alt_pkg::SH_LDECL] && len >= 8'd2)
      cls_o = alt_pkg::TK_LABELDECL;
    else if (word_i.shape[alt_pkg::SH_LABEL])
      cls_o = alt_pkg::TK_LABEL;
    else
      cls_o = alt_pkg::TK_UNKNOWN;
  end

endmodule

// File: sv/alt_out_buf.sv
module alt_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic [1:0]      push_cnt,
  input  alt_pkg::token_t tok0,
  input  alt_pkg::token_t tok1,
  output logic            ready,
  output logic            out_valid,
  input  logic            out_ready,
  output alt_pkg::token_t out_tok
);

  alt_pkg::token_t slot0_r, slot1_r;
  logic [1:0]      cnt_r;
  logic            pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_tok   = slot0_r;
  assign pop       = out_valid && out_ready;
  // a new item may land once the buffer drains in this cycle
  assign ready     = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (push && push_cnt != 2'd0) begin
      cnt_r <= push_cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_cnt != 2'd0) begin
      slot0_r <= tok0;
      slot1_r <= tok1;
    end else if (pop) begin
      slot0_r <= slot1_r;
    end
  end

endmodule

// File: sv/asm_line_tokenizer.sv
// Channel  Ports           Fields (low bit up)                 Transfer
// in       in_t*           tdata: ch[7:0]; tuser: line_end     tvalid & tready
// out      out_t*          tdata: length[7:0], column[15:8];   tvalid & tready
//                          tuser: token_class; tlast: last
//
// Each character is decoded and classified in the cycle it is accepted; its
// tokens are registered into a two-entry output buffer and appear next cycle.
// An item yielding zero or one token is taken every cycle while out_tready
// is high; one yielding two tokens (word plus delimiter or end-of-line)
// holds off the next item while the single output port drains the buffer.
// Reset (synchronous, active low) clears the line state and empties the
// buffer. in_tready falls while buffered tokens are not drained by out_tready.
module asm_line_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // ch
  input  logic        in_tuser,   // line_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // token_length, token_column
  output logic [4:0]  out_tuser,  // token_class
  output logic        out_tlast   // last
);

  localparam int PD = alt_pkg::PREFIX_DEPTH;

  logic       pb_r, pb_nxt;
  logic       ic_r, ic_nxt;
  logic [7:0] col_r, col_nxt;
  logic [7:0] wlen_r, wlen_nxt;
  logic [7:0] wstart_r, wstart_nxt;
  logic [4:0] shape_r, shape_nxt;
  logic [7:0] prefix_r [PD];

  logic                 accept;
  logic                 prefix_we;
  logic [7:0]           c;
  logic                 have_word, first, second;
  logic                 is_ws, is_delim, is_hash;
  logic                 dig, alpha, wordc, hexd;
  logic [4:0]           ok;
  logic [1:0]           n;
  alt_pkg::word_t       word;
  alt_pkg::tok_class_t  wcls;
  alt_pkg::token_t      wtok, etok, ptok, t0, t1, head;

  assign c = in_tdata;

  always_comb begin
    word.length = wlen_r;
    word.shape  = shape_r;
    for (int i = 0; i < alt_pkg::KW_CHARS; i++) word.prefix[i] = prefix_r[i];
  end

  alt_classify u_classify (
    .word_i (word),
    .cls_o  (wcls)
  );

  assign have_word = (wlen_r != 8'd0);
  assign first     = (wlen_r == 8'd0);
  assign second    = (wlen_r == 8'd1);
  assign is_ws     = (c == alt_pkg::CH_SPACE) || (c == alt_pkg::CH_TAB);
  assign is_delim  = (c == alt_pkg::CH_COMMA) || (c == alt_pkg::CH_AT) ||
                     (c == alt_pkg::CH_SEMI) || (c == alt_pkg::CH_LPAREN) ||
                     (c == alt_pkg::CH_RPAREN);
  assign is_hash   = (c == alt_pkg::CH_HASH);
  assign dig       = (c >= "0") && (c <= "9");
  assign alpha     = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  assign wordc     = alpha || dig || (c == "_");
  assign hexd      = dig || ((c >= "A") && (c <= "F"));

  always_comb begin
    ok[alt_pkg::SH_DEC]   = first ? (c == alt_pkg::CH_MINUS || dig) : dig;
    ok[alt_pkg::SH_HEX]   = first ? (c == alt_pkg::CH_ZERO) :
                            second ? (c == alt_pkg::CH_X) : hexd;
    ok[alt_pkg::SH_BIN]   = first ? (c == alt_pkg::CH_ZERO) :
                            second ? (c == alt_pkg::CH_B) :
                            (c == alt_pkg::CH_ZERO || c == alt_pkg::CH_ONE);
    ok[alt_pkg::SH_LDECL] = first ? (c == alt_pkg::CH_COLON) : second ? alpha : wordc;
    ok[alt_pkg::SH_LABEL] = first ? alpha : wordc;
  end

  always_comb begin
    wtok = '{cls: wcls, length: wlen_r, column: wstart_r, last: 1'b0};
    etok = '{cls: alt_pkg::TK_ENDL, length: 8'd1, column: col_r, last: 1'b0};
    ptok = '{cls: alt_pkg::punct_class(c), length: 8'd1, column: col_r, last: 1'b0};
  end

  always_comb begin
    pb_nxt     = pb_r;
    ic_nxt     = ic_r;
    col_nxt    = col_r;
    wlen_nxt   = wlen_r;
    wstart_nxt = wstart_r;
    shape_nxt  = shape_r;
    prefix_we  = 1'b0;
    n          = 2'd0;
    t0         = wtok;
    t1         = etok;
    if (in_tuser) begin
      if (!ic_r && have_word) begin
        n = 2'd2;
      end else begin
        t0 = etok;
        n  = 2'd1;
      end
      col_nxt  = 8'd0;
      pb_nxt   = 1'b0;
      ic_nxt   = 1'b0;
      wlen_nxt = 8'd0;
    end else if (!ic_r) begin
      col_nxt = (col_r == 8'hFF) ? col_r : col_r + 8'd1;
      pb_nxt  = (c == alt_pkg::CH_BSLASH);
      if (is_ws || (is_hash && !pb_r)) begin
        n        = have_word ? 2'd1 : 2'd0;
        wlen_nxt = 8'd0;
        ic_nxt   = !is_ws;
      end else if (is_delim && !pb_r) begin
        if (have_word) begin
          t1 = ptok;
          n  = 2'd2;
        end else begin
          t0 = ptok;
          n  = 2'd1;
        end
        wlen_nxt = 8'd0;
      end else begin
        if (first) wstart_nxt = col_r;
        shape_nxt = (first ? 5'h1F : shape_r) & ok;
        prefix_we = (wlen_r < 8'(PD));
        wlen_nxt  = (wlen_r < alt_pkg::WORD_CAP) ? wlen_r + 8'd1 : wlen_r;
      end
    end
    if (n == 2'd2) t1.last = 1'b1;
    else           t0.last = 1'b1;
  end

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_r     <= 1'b0;
      ic_r     <= 1'b0;
      col_r    <= 8'd0;
      wlen_r   <= 8'd0;
      wstart_r <= 8'd0;
      shape_r  <= 5'h1F;
    end else if (accept) begin
      pb_r     <= pb_nxt;
      ic_r     <= ic_nxt;
      col_r    <= col_nxt;
      wlen_r   <= wlen_nxt;
      wstart_r <= wstart_nxt;
      shape_r  <= shape_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && prefix_we) prefix_r[wlen_r[alt_pkg::PIDX_W-1:0]] <= c;
  end

  alt_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_cnt  (n),
    .tok0      (t0),
    .tok1      (t1),
    .ready     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (head)
  );

  assign out_tdata = {head.column, head.length};
  assign out_tuser = head.cls;
  assign out_tlast = head.last;

endmodule
